FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

FILE: rtl/ntm_pkg.sv
// constants and status codes for the nearest timestamp match unit
// no dependencies
package ntm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int TIME_W   = 32;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

endpackage

FILE: rtl/ntm_if.sv
// valid/ready channel interfaces for command beats and result beats
// depends on ntm_pkg
interface ntm_in_if;
    import ntm_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TIME_W-1:0] time_seconds;

    modport source (output valid, output cmd, output time_seconds, input ready);
    modport sink   (input valid, input cmd, input time_seconds, output ready);
endinterface

interface ntm_out_if;
    import ntm_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    match_index;
    logic [TIME_W-1:0]   min_difference;
    logic [STATUS_W-1:0] result_status;

    modport source (output valid, output match_index, output min_difference,
                    output result_status, input ready);
    modport sink   (input valid, input match_index, input min_difference,
                    input result_status, output ready);
endinterface

FILE: rtl/ntm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ntm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/nearest_timestamp_match_unit.sv
// top level of the nearest timestamp match unit: table control and scan sequencer
// depends on ntm_pkg, ntm_if, ntm_ram and assert_macros.svh
//
// usage:
//   in_ch carries command beats: cmd insert stores time_seconds in the next free
//   table slot, cmd query searches the stored timestamps for the smallest
//   absolute difference (lowest index wins a tie). out_ch carries exactly one
//   result beat per command beat, in order.
//   cfg_we / cfg_wdata write the tolerance register; write only while idle.
//   an insert or a query on an empty table goes from idle straight to the
//   done state; a query on a filled table passes through the scan state first.
//   one shared subtract/compare unit visits one entry per cycle, fed by the
//   single read port of the table ram. in_ch.ready is high only while the
//   sequencer is idle, so the next command can be taken in the cycle after a
//   result is loaded.
//   a result register holds the finished beat: while the receiver stalls the
//   unit still accepts and works on the next command, and waits to hand its
//   result over until the register is free.
//   reset empties the table (entry count zero) and clears the tolerance; no
//   clearing pass is needed, since only written entries are ever read.
module nearest_timestamp_match_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    ntm_in_if.sink                    in_ch,
    ntm_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [ntm_pkg::TIME_W-1:0] cfg_wdata
);
    import ntm_pkg::*;

    `include "assert_macros.svh"

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  issue_reg, issue_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                cmp_last_reg, cmp_last_next;
    logic [ADDR_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                is_scan_reg, is_scan_next;
    logic [TIME_W-1:0]   tol_reg;
    logic [TIME_W-1:0]   qtime_reg, qtime_next;
    logic [TIME_W-1:0]   best_diff_reg, best_diff_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    logic [STATUS_W-1:0] fixed_status_reg, fixed_status_next;

    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic [TIME_W-1:0]   out_diff_reg, out_diff_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                in_fire;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [TIME_W-1:0]   ram_rdata;
    logic [TIME_W-1:0]   cur_diff;
    logic                take_cur;
    logic [COUNT_W-1:0]  issue_inc;
    logic                out_free;
    logic [ADDR_W+IDX_W-1:0] idx_ext;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // timestamp table
    ntm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_ch.time_seconds),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // insert writes the next free slot while the table has room
    assign ram_we = in_fire && (in_ch.cmd == CMD_INSERT)
                    && (count_reg < COUNT_W'(TABLE_DEPTH));

    assign ram_raddr = issue_reg[ADDR_W-1:0];
    assign issue_inc = issue_reg + COUNT_W'(1);

    // shared subtract/compare unit
    assign cur_diff = (qtime_reg >= ram_rdata) ? (qtime_reg - ram_rdata)
                                               : (ram_rdata - qtime_reg);
    assign take_cur = (cmp_idx_reg == '0) || (cur_diff < best_diff_reg);

    // low bits of the index for the result field
    assign idx_ext = {{IDX_W{1'b0}}, best_idx_reg};

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        issue_next        = issue_reg;
        cmp_valid_next    = 1'b0;
        cmp_last_next     = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        is_scan_next      = is_scan_reg;
        qtime_next        = qtime_reg;
        best_diff_next    = best_diff_reg;
        best_idx_next     = best_idx_reg;
        fixed_status_next = fixed_status_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_idx_next      = out_idx_reg;
        out_diff_next     = out_diff_reg;
        out_status_next   = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    qtime_next     = in_ch.time_seconds;
                    best_diff_next = '0;
                    best_idx_next  = '0;
                    is_scan_next   = 1'b0;
                    state_next     = S_DONE;
                    if (in_ch.cmd == CMD_INSERT)
                    begin
                        if (count_reg < COUNT_W'(TABLE_DEPTH))
                        begin
                            best_idx_next     = count_reg[ADDR_W-1:0];
                            count_next        = count_reg + COUNT_W'(1);
                            fixed_status_next = ST_OK;
                        end
                        else
                        begin
                            fixed_status_next = ST_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        fixed_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        is_scan_next = 1'b1;
                        issue_next   = '0;
                        state_next   = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle
                if (issue_reg < count_reg)
                begin
                    issue_next     = issue_inc;
                    cmp_valid_next = 1'b1;
                    cmp_last_next  = (issue_inc == count_reg);
                    cmp_idx_next   = issue_reg[ADDR_W-1:0];
                end
                // compare the entry read last cycle
                if (cmp_valid_reg)
                begin
                    if (take_cur)
                    begin
                        best_diff_next = cur_diff;
                        best_idx_next  = cmp_idx_reg;
                    end
                    if (cmp_last_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_ext[IDX_W-1:0];
                    out_diff_next  = best_diff_reg;
                    if (is_scan_reg)
                    begin
                        out_status_next = (best_diff_reg <= tol_reg) ? ST_OK : ST_FAR;
                    end
                    else
                    begin
                        out_status_next = fixed_status_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tol_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg      <= cmp_idx_next;
        is_scan_reg      <= is_scan_next;
        qtime_reg        <= qtime_next;
        best_diff_reg    <= best_diff_next;
        best_idx_reg     <= best_idx_next;
        fixed_status_reg <= fixed_status_next;
        out_idx_reg      <= out_idx_next;
        out_diff_reg     <= out_diff_next;
        out_status_reg   <= out_status_next;
    end

    // ports
    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.match_index    = out_idx_reg;
    assign out_ch.min_difference = out_diff_reg;
    assign out_ch.result_status  = out_status_reg;

    // checks
    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > COUNT_W'(TABLE_DEPTH), "entry count beyond table depth")
    `ASSERT_PROP(a_cmp_in_scan, clk, rst_n, cmp_valid_reg |-> (state_reg == S_SCAN), "compare outside scan")
    `ASSERT_PROP(a_query_scans, clk, rst_n, (in_fire && in_ch.cmd == CMD_QUERY && count_reg != '0) |=> (state_reg == S_SCAN), "query on filled table did not scan")
    `ASSERT_PROP(a_insert_count, clk, rst_n, (in_fire && in_ch.cmd == CMD_INSERT && count_reg < COUNT_W'(TABLE_DEPTH)) |=> (count_reg == $past(count_reg) + COUNT_W'(1)), "insert did not advance entry count")

endmodule
